// ===== src/bpws_pkg.sv =====
// Package for the position-keyed word scrambler.
// Holds the item types, the offset step constant and the block-start key functions.
// No dependencies.
package bpws_pkg;

  localparam int unsigned BLOCK_WORDS_DEF = 128;
  localparam logic [31:0] OFFSET_STEP = 32'h561A_9C1A;
  localparam int unsigned KEY_ROT = 10;
  localparam int unsigned FB_ROT = 15;
  localparam int unsigned OFF_ROT_A = 7;
  localparam int unsigned OFF_ROT_B = 2;
  localparam logic [31:0] WORD_BYTES = 32'd4;

  typedef struct packed {
    logic [31:0] data_word;
    logic        last_word;
  } plain_t;

  typedef struct packed {
    logic [31:0] cipher_word;
    logic        last_out;
  } cipher_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] pos_hash(input logic [31:0] p);
    pos_hash = (p + (p >> 8)) + ((p >> 16) + (p >> 24));
  endfunction

  function automatic logic [31:0] pos_offset(input logic [31:0] p);
    logic [31:0] v;
    v = p + rotr(p, OFF_ROT_A);
    pos_offset = v + rotr(v, OFF_ROT_B);
  endfunction

endpackage

// ===== src/bpws_core.sv =====
// Scrambling datapath and rolling state for the position-keyed word scrambler.
// Computes one cipher word per transaction and advances the block state.
// Depends on bpws_pkg.
module bpws_core #(
  parameter int unsigned BLOCK_WORDS = bpws_pkg::BLOCK_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  bpws_pkg::plain_t  item,
  input  logic [31:0]       seed,
  output bpws_pkg::cipher_t result
);

  localparam int unsigned IDX_W = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BLOCK_WORDS - 1);

  logic [IDX_W-1:0] word_index;
  logic [31:0]      byte_position;
  logic [31:0]      rolling_key;
  logic [31:0]      rolling_offset;
  logic [31:0]      feedback_word;

  logic        block_start;
  logic [31:0] cur_key;
  logic [31:0] cur_off;
  logic [31:0] cur_fb;
  logic [31:0] cipher_word;

  always_comb begin
    block_start = (word_index == '0);
    if (block_start) begin
      cur_key = seed ^ bpws_pkg::pos_hash(byte_position);
      cur_off = bpws_pkg::pos_offset(byte_position);
      cur_fb  = '0;
    end else begin
      cur_key = rolling_key;
      cur_off = rolling_offset;
      cur_fb  = feedback_word;
    end
    cipher_word = item.data_word ^ cur_fb ^ cur_key ^ cur_off;
    result.cipher_word = cipher_word;
    result.last_out    = item.last_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index     <= '0;
      byte_position  <= '0;
      rolling_key    <= '0;
      rolling_offset <= '0;
      feedback_word  <= '0;
    end else if (go) begin
      rolling_key    <= bpws_pkg::rotr(cur_key, bpws_pkg::KEY_ROT);
      rolling_offset <= cur_off + bpws_pkg::OFFSET_STEP;
      if (item.last_word) begin
        word_index    <= '0;
        byte_position <= '0;
        feedback_word <= '0;
      end else begin
        word_index    <= (word_index == IDX_LAST) ? '0 : word_index + 1'b1;
        byte_position <= byte_position + bpws_pkg::WORD_BYTES;
        feedback_word <= bpws_pkg::rotr(cipher_word, bpws_pkg::FB_ROT);
      end
    end
  end

endmodule

// ===== src/block_position_keyed_word_scrambler_unit.sv =====
// Top level of the position-keyed word scrambler: input register, core, result register.
// A word passes the input register, then the result register (cipher_valid); one word per cycle when unstalled.
// A stalled result holds the core, so the input stalls once the input register is also full.
// The seed write port is always ready; a new seed applies from the next block start.
// Synchronous reset clears position, block state, seed and both register valids.
// Depends on bpws_pkg and bpws_core.
module block_position_keyed_word_scrambler_unit #(
  parameter int unsigned BLOCK_WORDS = bpws_pkg::BLOCK_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              plain_valid,
  output logic              plain_stall,
  input  bpws_pkg::plain_t  plain,
  output logic              cipher_valid,
  input  logic              cipher_stall,
  output bpws_pkg::cipher_t cipher,
  input  logic              seed_valid,
  output logic              seed_ready,
  input  logic [31:0]       seed
);

  logic              in_full;
  bpws_pkg::plain_t  in_item;
  logic              out_full;
  bpws_pkg::cipher_t out_item;
  logic [31:0]       seed_reg;
  logic              advance;
  logic              take;
  bpws_pkg::cipher_t result;

  assign advance      = in_full && (!out_full || !cipher_stall);
  assign plain_stall  = in_full && !advance;
  assign take         = plain_valid && !plain_stall;
  assign cipher_valid = out_full;
  assign cipher       = out_item;
  assign seed_ready   = 1'b1;

  bpws_core #(
    .BLOCK_WORDS(BLOCK_WORDS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .go     (advance),
    .item   (in_item),
    .seed   (seed_reg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_reg <= '0;
    end else if (seed_valid && seed_ready) begin
      seed_reg <= seed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= take || (in_full && !advance);
    end
    if (take) begin
      in_item <= plain;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (!cipher_stall) begin
      out_full <= 1'b0;
    end
    if (advance) begin
      out_item <= result;
    end
  end

endmodule

// ===== dv/block_position_keyed_word_scrambler_unit_test.sv =====
// Self-checking testbench for the position-keyed word scrambler.
// Drives word streams with seed changes and random idling and stalls, predicting every
// cipher transaction in its own model. Depends on bpws_pkg and the scrambler top level.
module block_position_keyed_word_scrambler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 400000;
  localparam int BLOCK_LEN = int'(bpws_pkg::BLOCK_WORDS_DEF);
  localparam int PHASE_WORDS = 400;
  localparam int PLAN_ROWS = 12;

  typedef struct packed {
    logic [31:0] data_word;
    logic        last_word;
    logic        pinned;
    logic [31:0] want;
  } plan_row_t;

  typedef struct packed {
    logic              on;
    bpws_pkg::cipher_t want;
  } known_cipher_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              plain_valid = 1'b0;
  logic              plain_stall;
  bpws_pkg::plain_t  plain = '0;
  logic              cipher_valid;
  logic              cipher_stall = 1'b0;
  bpws_pkg::cipher_t cipher;
  logic              seed_valid = 1'b0;
  logic              seed_ready;
  logic [31:0]       seed = '0;

  logic [31:0] seed_now = '0;
  int          blk_word = 0;
  logic [31:0] byte_pos = '0;
  logic [31:0] key_word = '0;
  logic [31:0] offset_word = '0;
  logic [31:0] fb_word = '0;

  known_cipher_t     known_cipher_q[$];
  bpws_pkg::cipher_t pending_cipher_q[$];
  int                bad_count = 0;
  int                cycle_count = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                file_left = 0;

  // Files of one word, and the first word of each longer file, are pinned to values that
  // follow directly from a zero seed at position zero.
  plan_row_t word_plan [PLAN_ROWS] = '{
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF},
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{32'h8000_0001, 1'b1, 1'b0, 32'h0},
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{32'h1234_5678, 1'b1, 1'b1, 32'h1234_5678},
    '{32'h0000_00AB, 1'b1, 1'b1, 32'h0000_00AB},
    '{32'h0000_CDEF, 1'b0, 1'b1, 32'h0000_CDEF},
    '{32'h55AA_55AA, 1'b0, 1'b0, 32'h0},
    '{32'hAAAA_5555, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
    '{32'h00AB_CDEF, 1'b1, 1'b1, 32'h00AB_CDEF}
  };

  block_position_keyed_word_scrambler_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .plain_valid  (plain_valid),
    .plain_stall  (plain_stall),
    .plain        (plain),
    .cipher_valid (cipher_valid),
    .cipher_stall (cipher_stall),
    .cipher       (cipher),
    .seed_valid   (seed_valid),
    .seed_ready   (seed_ready),
    .seed         (seed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    logic [63:0] both;
    both = {x, x} >> n;
    return both[31:0];
  endfunction

  function automatic bpws_pkg::cipher_t scramble_word(input bpws_pkg::plain_t w);
    logic [31:0]       p;
    logic [31:0]       v;
    logic [31:0]       c;
    bpws_pkg::cipher_t r;
    if (blk_word == 0) begin
      p = byte_pos;
      key_word = seed_now ^ (p + (p >> 8) + (p >> 16) + (p >> 24));
      v = p + ror32(p, bpws_pkg::OFF_ROT_A);
      offset_word = v + ror32(v, bpws_pkg::OFF_ROT_B);
      fb_word = '0;
    end
    c = w.data_word ^ fb_word ^ key_word ^ offset_word;
    key_word = ror32(key_word, bpws_pkg::KEY_ROT);
    fb_word = ror32(c, bpws_pkg::FB_ROT);
    offset_word = offset_word + bpws_pkg::OFFSET_STEP;
    byte_pos = byte_pos + bpws_pkg::WORD_BYTES;
    blk_word = (blk_word + 1) % BLOCK_LEN;
    if (w.last_word) begin
      blk_word = 0;
      byte_pos = '0;
      fb_word = '0;
    end
    r.cipher_word = c;
    r.last_out = w.last_word;
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("block_position_keyed_word_scrambler_unit: mismatch");
      $finish;
    end
  end

  always @(negedge clk) begin
    cipher_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin : watch
    known_cipher_t     known;
    bpws_pkg::cipher_t pred;
    bpws_pkg::cipher_t want;
    if (!rst && plain_valid && !plain_stall) begin
      known = known_cipher_q.pop_front();
      pred = scramble_word(plain);
      pending_cipher_q.push_back(known.on ? known.want : pred);
    end
    if (!rst && cipher_valid && !cipher_stall) begin
      if (pending_cipher_q.size() == 0) begin
        bad_count++;
        $display("%0t: cipher transaction expected none actual %h", $time, cipher);
      end else begin
        want = pending_cipher_q.pop_front();
        if (cipher.cipher_word !== want.cipher_word) begin
          bad_count++;
          $display("%0t: cipher_word expected %h actual %h", $time, want.cipher_word,
                   cipher.cipher_word);
        end
        if (cipher.last_out !== want.last_out) begin
          bad_count++;
          $display("%0t: last_out expected %b actual %b", $time, want.last_out,
                   cipher.last_out);
        end
      end
    end
  end

  task automatic push_word(input bpws_pkg::plain_t w, input known_cipher_t known);
    known_cipher_q.push_back(known);
    while ($urandom_range(99) < send_idle_pct) begin
      plain_valid <= 1'b0;
      @(negedge clk);
    end
    plain_valid <= 1'b1;
    plain <= w;
    do @(posedge clk); while (plain_stall);
    @(negedge clk);
  endtask

  task automatic write_seed(input logic [31:0] v);
    seed_valid <= 1'b1;
    seed <= v;
    do @(posedge clk); while (!seed_ready);
    seed_now = v;
    @(negedge clk);
    seed_valid <= 1'b0;
  endtask

  task automatic drain();
    plain_valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (pending_cipher_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic push_random(input int n_words);
    bpws_pkg::plain_t w;
    known_cipher_t    none;
    none = '0;
    for (int i = 0; i < n_words; i++) begin
      if (file_left == 0) begin
        case ($urandom_range(9))
          0, 1: file_left = $urandom_range(1, 4);
          7: file_left = BLOCK_LEN;
          8: file_left = 2 * BLOCK_LEN;
          9: file_left = $urandom_range(BLOCK_LEN - 1, BLOCK_LEN + 1);
          default: file_left = $urandom_range(100, 300);
        endcase
      end
      case ($urandom_range(7))
        0: w.data_word = 32'h0000_0000;
        1: w.data_word = 32'hFFFF_FFFF;
        2: w.data_word = $urandom & (32'hFFFF_FFFF >> (8 * $urandom_range(1, 3)));
        default: w.data_word = $urandom;
      endcase
      w.last_word = (file_left == 1) || ($urandom_range(99) == 0);
      file_left = w.last_word ? 0 : file_left - 1;
      push_word(w, none);
    end
  endtask

  initial begin : stimulus
    plan_row_t        row;
    known_cipher_t    known;
    bpws_pkg::plain_t w;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_seed(32'h0000_0000);
    foreach (word_plan[i]) begin
      row = word_plan[i];
      w.data_word = row.data_word;
      w.last_word = row.last_word;
      known.on = row.pinned;
      known.want.cipher_word = row.want;
      known.want.last_out = row.last_word;
      push_word(w, known);
    end
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: write_seed(32'hFFFF_FFFF);
        2: write_seed(32'h0000_0000);
        default: write_seed($urandom);
      endcase
      case (ph)
        1: send_idle_pct = 82;
        2: recv_stall_pct = 82;
        3: begin
          send_idle_pct = 26;
          recv_stall_pct = 26;
        end
        default: ;
      endcase
      push_random(PHASE_WORDS);
    end
    drain();
    if (bad_count == 0) begin
      $display("block_position_keyed_word_scrambler_unit: match");
    end else begin
      $display("block_position_keyed_word_scrambler_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/bpws_pkg.sv
src/bpws_core.sv
src/block_position_keyed_word_scrambler_unit.sv
dv/block_position_keyed_word_scrambler_unit_test.sv
